/* sv/gfa_pkg.sv */
// ----------------------------------------------------------------------------
// gfa_pkg
// Types, constants and field arithmetic shared by the GF(2^w) ALU pipeline.
// ----------------------------------------------------------------------------
package gfa_pkg;

	localparam int MaxFieldBits = 16;
	localparam int ProdBits     = 2 * MaxFieldBits - 1;
	localparam int ExpStages    = 16;

	// field size select codes
	localparam logic [1:0] ModeGf16  = 2'd0;
	localparam logic [1:0] ModeGf256 = 2'd1;

	// operation codes
	localparam logic [1:0] OpXor = 2'd0;
	localparam logic [1:0] OpMul = 2'd1;
	localparam logic [1:0] OpDiv = 2'd2;
	localparam logic [1:0] OpPow = 2'd3;

	// primitive polynomials, top bit included
	localparam logic [16:0] PolyW4  = 17'o23;
	localparam logic [16:0] PolyW8  = 17'o435;
	localparam logic [16:0] PolyW16 = 17'o210013;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic [15:0] result;
		logic        divide_by_zero;
	} out_item_t;

	// state carried through the exponent stages
	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] x;
		logic [15:0] acc;
		logic [15:0] e;
		logic [15:0] f;
		logic        dbz;
	} pipe_t;

	function automatic logic [4:0] field_bits(input logic [1:0] mode);
		logic [4:0] bits;
		case (mode)
			ModeGf16:  bits = 5'd4;
			ModeGf256: bits = 5'd8;
			default:   bits = 5'd16;
		endcase
		return bits;
	endfunction

	function automatic logic [15:0] field_mask(input logic [1:0] mode);
		logic [15:0] m;
		case (mode)
			ModeGf16:  m = 16'h000f;
			ModeGf256: m = 16'h00ff;
			default:   m = 16'hffff;
		endcase
		return m;
	endfunction

	function automatic logic [16:0] field_poly(input logic [1:0] mode);
		logic [16:0] p;
		case (mode)
			ModeGf16:  p = PolyW4;
			ModeGf256: p = PolyW8;
			default:   p = PolyW16;
		endcase
		return p;
	endfunction

	// carry-less product followed by reduction modulo the field polynomial
	function automatic logic [15:0] gf_mul(input logic [15:0] a, input logic [15:0] b,
			input logic [1:0] mode);
		logic [ProdBits-1:0] p;
		logic [ProdBits-1:0] poly_ext;
		logic [4:0]          bits;
		logic [15:0]         m;
		m        = field_mask(mode);
		bits     = field_bits(mode);
		poly_ext = {{(ProdBits-17){1'b0}}, field_poly(mode)};
		p        = '0;
		for (int i = 0; i < MaxFieldBits; i++) begin
			if (b[i] & m[i])
				p = p ^ ({{(ProdBits-16){1'b0}}, a & m} << i);
		end
		for (int i = ProdBits - 1; i >= 4; i--) begin
			if (i >= int'(bits) && p[i])
				p = p ^ (poly_ext << (i - int'(bits)));
		end
		return p[15:0] & m;
	endfunction

endpackage

/* sv/galois_field_alu_core.sv */
// ----------------------------------------------------------------------------
// galois_field_alu_core
// XOR, multiply, divide and power over GF(16), GF(256) or GF(65536).
// ----------------------------------------------------------------------------
// Accepts one item per clock while no backpressure stalls the pipe, and returns
// each result after one decode stage, sixteen square-and-multiply stages (one per
// exponent bit) and one final multiply stage. Every operation runs through
// the same chain as x^e times f, so latency does not depend on the operation.
// Each stage has its own valid bit and stalls only when the stage after it is
// full, so the pipe keeps taking items until backpressure fills it. Write
// width_mode only while no item is in flight.
module galois_field_alu_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  gfa_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output gfa_pkg::out_item_t out_data
);

	localparam int NStg = gfa_pkg::ExpStages;

	logic [1:0]     width_mode_q;
	logic           valid_s1;
	gfa_pkg::pipe_t data_s1;
	gfa_pkg::pipe_t dec;
	logic [15:0]    m;
	logic [15:0]    a_m;
	logic [15:0]    b_m;

	logic           stg_valid [NStg+1];
	logic           stg_ready [NStg+1];
	gfa_pkg::pipe_t stg_data  [NStg+1];

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= gfa_pkg::ModeGf16;
		end else if (cfg_valid) begin
			width_mode_q <= cfg_data;
		end
	end

	// decode the item into base, exponent and post factor
	always_comb begin
		m        = gfa_pkg::field_mask(width_mode_q);
		a_m      = in_data.operand_a & m;
		b_m      = in_data.operand_b & m;
		dec.mode = width_mode_q;
		dec.acc  = 16'd1;
		dec.dbz  = 1'b0;
		case (in_data.op)
			gfa_pkg::OpXor: begin
				dec.x = 16'd0;
				dec.e = 16'd0;
				dec.f = a_m ^ b_m;
			end
			gfa_pkg::OpMul: begin
				dec.x = b_m;
				dec.e = 16'd1;
				dec.f = a_m;
			end
			gfa_pkg::OpDiv: begin
				dec.x   = b_m;
				dec.e   = m - 16'd1;
				dec.f   = a_m;
				dec.dbz = (a_m != 16'd0) && (b_m == 16'd0);
			end
			default: begin
				dec.x = a_m;
				dec.e = in_data.operand_b;
				dec.f = 16'd1;
			end
		endcase
	end

	assign in_ready = !valid_s1 || stg_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= dec;
		end
	end

	assign stg_valid[0] = valid_s1;
	assign stg_data[0]  = data_s1;

	// exponent chain
	for (genvar g = 0; g < NStg; g++) begin : g_exp
		gfa_exp_stage u_exp (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stg_valid[g]),
			.up_ready (stg_ready[g]),
			.up_data  (stg_data[g]),
			.dn_valid (stg_valid[g+1]),
			.dn_ready (stg_ready[g+1]),
			.dn_data  (stg_data[g+1])
		);
	end

	gfa_final_stage u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (stg_valid[NStg]),
		.up_ready (stg_ready[NStg]),
		.up_data  (stg_data[NStg]),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (out_data)
	);

	// checks
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |-> out_data.result == 16'd0)
		else $error("divide by zero with nonzero result");

	a_gf16_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && width_mode_q == gfa_pkg::ModeGf16 |-> out_data.result[15:4] == 12'd0)
		else $error("result outside GF(16)");

	a_gf256_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && width_mode_q == gfa_pkg::ModeGf256 |-> out_data.result[15:8] == 8'd0)
		else $error("result outside GF(256)");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

/* sv/gfa_exp_stage.sv */
// ----------------------------------------------------------------------------
// gfa_exp_stage
// One square-and-multiply step: consumes the low exponent bit.
// ----------------------------------------------------------------------------
module gfa_exp_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  gfa_pkg::pipe_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output gfa_pkg::pipe_t dn_data
);

	logic           valid_s1;
	gfa_pkg::pipe_t data_s1;
	gfa_pkg::pipe_t next;

	assign up_ready = !valid_s1 || dn_ready;

	// multiply accumulator when bit set, square the base
	always_comb begin
		next     = up_data;
		next.acc = up_data.e[0] ? gfa_pkg::gf_mul(up_data.acc, up_data.x, up_data.mode)
			: up_data.acc;
		next.x   = gfa_pkg::gf_mul(up_data.x, up_data.x, up_data.mode);
		next.e   = {1'b0, up_data.e[15:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

/* sv/gfa_final_stage.sv */
// ----------------------------------------------------------------------------
// gfa_final_stage
// Multiplies the exponent result by the post factor and forms the result item.
// ----------------------------------------------------------------------------
module gfa_final_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  gfa_pkg::pipe_t     up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output gfa_pkg::out_item_t dn_data
);

	logic               valid_s1;
	gfa_pkg::out_item_t data_s1;

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// final product
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1.result         <= gfa_pkg::gf_mul(up_data.acc, up_data.f, up_data.mode);
			data_s1.divide_by_zero <= up_data.dbz;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

/* test/tb_galois_field_alu_core.sv */
// ----------------------------------------------------------------------------
// tb_galois_field_alu_core
// Self-checking bench for the GF(2^w) ALU: directed corner items and random
// traffic in every field size, checked against a behavioral field model.
// ----------------------------------------------------------------------------
module tb_galois_field_alu_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles   = 40;
	localparam logic [1:0] ModeGf65536 = 2'd2;
	localparam logic [1:0] ModeSpare   = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	gfa_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	gfa_pkg::out_item_t out_data;

	logic [1:0]         field_mode;
	gfa_pkg::out_item_t pending_results[$];
	int                 mismatch_count;
	int                 checked_count;
	int                 idle_cycles;
	bit                 timed_out;
	int                 burst_left;

	galois_field_alu_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// field model helpers
	function automatic int unsigned mode_bits(input logic [1:0] mode);
		case (mode)
			gfa_pkg::ModeGf16:  return 4;
			gfa_pkg::ModeGf256: return 8;
			default:            return 16;
		endcase
	endfunction

	function automatic logic [16:0] mode_poly(input logic [1:0] mode);
		case (mode)
			gfa_pkg::ModeGf16:  return 17'o23;
			gfa_pkg::ModeGf256: return 17'o435;
			default:            return 17'o210013;
		endcase
	endfunction

	// shift-and-add multiply with reduction at each step
	function automatic logic [15:0] field_product(input logic [15:0] x, input logic [15:0] y,
			input logic [1:0] mode);
		int unsigned bits;
		logic [16:0] poly;
		logic [16:0] sh;
		logic [16:0] acc;
		bits = mode_bits(mode);
		poly = mode_poly(mode);
		sh   = {1'b0, x};
		acc  = '0;
		for (int i = 0; i < bits; i++) begin
			if (y[i])
				acc ^= sh;
			sh = sh << 1;
			if (sh[bits])
				sh ^= poly;
		end
		return acc[15:0];
	endfunction

	function automatic logic [15:0] field_power(input logic [15:0] x, input logic [15:0] n,
			input logic [1:0] mode);
		logic [15:0] acc;
		acc = 16'd1;
		for (int i = 0; i < 16; i++) begin
			if (n[i])
				acc = field_product(acc, x, mode);
			x = field_product(x, x, mode);
		end
		return acc;
	endfunction

	function automatic gfa_pkg::out_item_t alu_outcome(input gfa_pkg::in_item_t item,
			input logic [1:0] mode);
		logic [15:0]        mask;
		logic [15:0]        a;
		logic [15:0]        b;
		gfa_pkg::out_item_t r;
		mask = 16'((32'd1 << mode_bits(mode)) - 1);
		a    = item.operand_a & mask;
		b    = item.operand_b & mask;
		r    = '0;
		case (item.op)
			gfa_pkg::OpXor: r.result = a ^ b;
			gfa_pkg::OpMul: r.result = field_product(a, b, mode);
			gfa_pkg::OpDiv: begin
				if (a != 0 && b == 0)
					r.divide_by_zero = 1'b1;
				else if (a != 0)
					r.result = field_product(a, field_power(b, mask - 16'd1, mode), mode);
			end
			default: r.result = field_power(a, item.operand_b, mode);
		endcase
		return r;
	endfunction

	// receiver stall pattern: long open stretches, then choppy phases
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			case (($urandom_range(0, 3) == 0) ? 2'd1 : checked_count[8:7])
				2'd0:    out_ready <= 1'b1;
				2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
				2'd2:    out_ready <= ($urandom_range(0, 1) == 0);
				default: out_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		gfa_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected item: result %h dbz %b", out_data.result,
						out_data.divide_by_zero);
			end else begin
				want = pending_results.pop_front();
				if (out_data.result !== want.result
						|| out_data.divide_by_zero !== want.divide_by_zero) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %h/%b got %h/%b", want.result,
							want.divide_by_zero, out_data.result, out_data.divide_by_zero);
				end
			end
			checked_count++;
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit && !timed_out) begin
			timed_out = 1'b1;
			$display("watchdog expired");
			$display("FAILURE");
			$finish;
		end
	end

	// send one item, with burst/gap pacing; valid stays high inside a burst
	task automatic send_op(input logic [1:0] op, input logic [15:0] a, input logic [15:0] b);
		gfa_pkg::in_item_t item;
		int                gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		item.op        = op;
		item.operand_a = a;
		item.operand_b = b;
		in_valid <= 1'b1;
		in_data  <= item;
		pending_results.push_back(alu_outcome(item, field_mode));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_field(input logic [1:0] mode);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		field_mode = mode;
	endtask

	// corner items for the current field
	task automatic test_corners();
		logic [15:0] top;
		top = 16'((32'd1 << mode_bits(field_mode)) - 1);
		send_op(gfa_pkg::OpXor, 16'hffff, 16'h0000);
		send_op(gfa_pkg::OpXor, 16'h0000, 16'hffff);
		send_op(gfa_pkg::OpMul, 16'h0000, top);
		send_op(gfa_pkg::OpMul, top, 16'h0000);
		send_op(gfa_pkg::OpMul, top, top);
		send_op(gfa_pkg::OpMul, 16'h0001, 16'hffff);
		send_op(gfa_pkg::OpDiv, 16'h0000, 16'h0000);
		send_op(gfa_pkg::OpDiv, 16'h0000, top);
		send_op(gfa_pkg::OpDiv, top, 16'h0000);
		send_op(gfa_pkg::OpDiv, 16'hffff, 16'h0001);
		send_op(gfa_pkg::OpDiv, top, top);
		send_op(gfa_pkg::OpPow, 16'h0000, 16'h0000);
		send_op(gfa_pkg::OpPow, top, 16'h0000);
		send_op(gfa_pkg::OpPow, 16'h0000, 16'h0005);
		send_op(gfa_pkg::OpPow, 16'h0002, 16'hffff);
		send_op(gfa_pkg::OpPow, 16'h0002, top);
		send_op(gfa_pkg::OpPow, 16'hffff, 16'h8000);
		// divisor that is zero after masking to the field width
		send_op(gfa_pkg::OpDiv, 16'h0001, 16'hfff0 & ~top);
	endtask

	// random operations, some with small operands to hit zero and one often
	task automatic test_random_ops(input int count);
		logic [15:0] a;
		logic [15:0] b;
		for (int i = 0; i < count; i++) begin
			a = 16'($urandom());
			b = 16'($urandom());
			if ($urandom_range(0, 7) == 0) a = 16'($urandom_range(0, 2));
			if ($urandom_range(0, 7) == 0) b = 16'($urandom_range(0, 2));
			send_op(2'($urandom_range(0, 3)), a, b);
		end
	endtask

	// stimulus
	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		in_data    = '0;
		field_mode = gfa_pkg::ModeGf16;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the field size first
		test_corners();
		test_random_ops(150);
		set_field(gfa_pkg::ModeGf256);
		test_corners();
		test_random_ops(250);
		set_field(ModeGf65536);
		test_corners();
		test_random_ops(250);
		set_field(ModeSpare);
		test_random_ops(100);
		set_field(gfa_pkg::ModeGf16);
		test_random_ops(100);
		set_field(gfa_pkg::ModeGf256);
		test_random_ops(100);
		wait_drained();

		$display("covered xor, multiply, divide and power in GF(16), GF(256), GF(65536)");
		$display("and the spare mode code; %0d results checked", checked_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/gfa_pkg.sv
sv/gfa_exp_stage.sv
sv/gfa_final_stage.sv
sv/galois_field_alu_core.sv
test/tb_galois_field_alu_core.sv
